// ----- src/bta_pkg.sv -----
// ----------------------------------------------------------------------------
// bta_pkg: shared types and constants for the boundary tag heap allocator
// Marker word layout, request and status codes, sequencer states and the
// bundles that travel between the sequencer and the marker store.
// ----------------------------------------------------------------------------
package bta_pkg;

  // Store geometry and marker layout.
  localparam int STORE_DEPTH  = 4096;
  localparam int ADDR_W       = 12;
  localparam int UA_W         = 16;
  localparam int MARKER_SHIFT = 2;  // four bytes per marker unit
  localparam logic [14:0] SIZE_MASK = 15'h7fff;
  localparam logic [11:0] MAX_UNITS = 12'(STORE_DEPTH - 1);
  localparam logic [11:0] MIN_UNITS = 12'd2;

  typedef logic [UA_W-1:0] ua_t;

  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_EXTEND = 2'd2,
    REQ_CHECK  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_SPACE  = 3'd1,
    ST_BAD_PTR   = 3'd2,
    ST_CHECK_BAD = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

  typedef enum logic [5:0] {
    S_CLEAR, S_INIT0, S_INIT1, S_IDLE,
    S_A_RD, S_A_EV, S_A_END,
    S_SP0, S_SP1, S_SP2, S_SP3, S_SP_DONE,
    S_F_RD, S_F_EV, S_F_CHK, S_F_CHK2, S_F_W2, S_F_C1, S_F_PRV, S_F_PRV2, S_F_HINT,
    S_C_RD0, S_C_E0, S_C_E1, S_C_W2,
    S_E1, S_E_RD, S_E2, S_E_W2, S_E_W3, S_E_DONE,
    S_CK_LOOP, S_CK_ACC, S_CK_FIN,
    S_RO0, S_RO1, S_RO2, S_RO3, S_RO4, S_RO5,
    S_WH_RD, S_WH_WR, S_FIN
  } state_t;

  // Port bundle from the sequencer to the marker store.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [31:0]       wdata;
    ua_t               raddr;
  } mem_req_t;

  // Pending half-word update: which marker, which half, the new half and
  // where the sequencer resumes afterwards.
  typedef struct packed {
    ua_t         addr;
    logic        hi;
    logic [15:0] val;
    state_t      ret;
  } wh_op_t;

  function automatic wh_op_t mk_wh(ua_t addr, logic hi, logic fr, ua_t size, state_t ret);
    wh_op_t op;
    op.addr = addr;
    op.hi   = hi;
    op.val  = {fr, size[14:0] & SIZE_MASK};
    op.ret  = ret;
    return op;
  endfunction

endpackage

// ----- src/bta_store.sv -----
// ----------------------------------------------------------------------------
// bta_store: marker word memory
// One write and one read port; read data is registered, and a read beyond
// the store returns zero.
// ----------------------------------------------------------------------------
module bta_store
  import bta_pkg::*;
(
  input  logic        clk,
  input  mem_req_t    req,
  output logic [31:0] rdata
);

  logic [31:0] mem [STORE_DEPTH];
  logic [31:0] q_r;
  logic        oob_r;

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    q_r   <= mem[req.raddr[ADDR_W-1:0]];
    oob_r <= (req.raddr[UA_W-1:ADDR_W] != '0);
  end

  assign rdata = oob_r ? 32'h0 : q_r;

endmodule

// ----- src/boundary_tag_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator: best-fit heap allocator over boundary markers
// Top level with the request sequencer, heap registers and result register.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 4096-entry marker store to zero, one word
// a cycle, then writes the two initial markers; in_ready stays low until
// then, and after every heap_units write until both markers are rewritten.
// Each word is then worked by one sequencer around a single memory port with
// registered reads: an allocate walks the region chain from the hint (again
// from the base if that walk finds no fit) and then splits the chosen region,
// a free walks the regions in front of the pointer and then updates the
// markers and merges, an extend rewrites the end markers, and a check reads
// every region. The result is held in an output register, and the next word
// is taken once the sequencer is back in idle.
module boundary_tag_heap_allocator
  import bta_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [16:0] in_byte_count,
  input  logic [11:0] in_ptr_unit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [11:0] out_data_unit,
  output logic [13:0] out_free_bytes
);

  state_t      state_r, state_nxt;
  logic        pend_r, pend_nxt;
  logic [11:0] clr_r, clr_nxt;
  logic [11:0] heap_units_r, heap_units_nxt;
  logic [11:0] heap_end_r, heap_end_nxt;
  logic [11:0] hint_r, hint_nxt;
  ua_t         free_units_r, free_units_nxt;
  ua_t         cur_r, cur_nxt;
  ua_t         start_r, start_nxt;
  ua_t         best_r, best_nxt;
  ua_t         bsize_r, bsize_nxt;
  logic        found_r, found_nxt;
  ua_t         units_r, units_nxt;
  ua_t         m_r, m_nxt;
  ua_t         s_r, s_nxt;
  ua_t         x_r, x_nxt;
  ua_t         xs_r, xs_nxt;
  logic        xf_r, xf_nxt;
  ua_t         total_r, total_nxt;
  logic [31:0] w_r, w_nxt;
  ua_t         ro_m_r, ro_m_nxt;
  state_t      ro_ret_r, ro_ret_nxt;
  state_t      co_ret_r, co_ret_nxt;
  wh_op_t      wh_r, wh_nxt;
  status_t     status_r, status_nxt;
  logic [11:0] data_r, data_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_status_r, out_status_nxt;
  logic [11:0] out_data_r, out_data_nxt;
  logic [13:0] out_free_r, out_free_nxt;

  mem_req_t    mreq;
  logic [31:0] q;

  // Views of the word just read.
  ua_t  q_nsz, q_psz;
  logic q_nfr, q_pfr;
  ua_t  cut, tail, ext_size, alloc_units;
  logic [16:0] ext_end;
  logic [11:0] clamp_units;

  bta_store u_store (
    .clk   (clk),
    .req   (mreq),
    .rdata (q)
  );

  assign q_nsz = {1'b0, q[30:16]};
  assign q_nfr = q[31];
  assign q_psz = {1'b0, q[14:0]};
  assign q_pfr = q[15];

  assign cut         = best_r + units_r;
  assign tail        = best_r + bsize_r;
  assign ext_size    = q_nsz + units_r;
  assign ext_end     = {1'b0, m_r} + {1'b0, ext_size};
  assign alloc_units = UA_W'(({1'b0, in_byte_count} + 18'd7) >> MARKER_SHIFT);
  assign clamp_units = (cfg_wdata < MIN_UNITS) ? MIN_UNITS :
                       (cfg_wdata > MAX_UNITS) ? MAX_UNITS : cfg_wdata;

  assign in_ready = (state_r == S_IDLE) && !pend_r;

  // Sequencer: next state, memory port and heap register updates.
  always_comb begin
    state_nxt      = state_r;
    pend_nxt       = pend_r;
    clr_nxt        = clr_r;
    heap_units_nxt = heap_units_r;
    heap_end_nxt   = heap_end_r;
    hint_nxt       = hint_r;
    free_units_nxt = free_units_r;
    cur_nxt        = cur_r;
    start_nxt      = start_r;
    best_nxt       = best_r;
    bsize_nxt      = bsize_r;
    found_nxt      = found_r;
    units_nxt      = units_r;
    m_nxt          = m_r;
    s_nxt          = s_r;
    x_nxt          = x_r;
    xs_nxt         = xs_r;
    xf_nxt         = xf_r;
    total_nxt      = total_r;
    w_nxt          = w_r;
    ro_m_nxt       = ro_m_r;
    ro_ret_nxt     = ro_ret_r;
    co_ret_nxt     = co_ret_r;
    wh_nxt         = wh_r;
    status_nxt     = status_r;
    data_nxt       = data_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_free_nxt   = out_free_r;
    mreq.we        = 1'b0;
    mreq.waddr     = '0;
    mreq.wdata     = '0;
    mreq.raddr     = '0;

    unique case (state_r)
      S_CLEAR: begin
        mreq.we    = 1'b1;
        mreq.waddr = clr_r;
        clr_nxt    = clr_r + 12'd1;
        if (clr_r == MAX_UNITS) begin
          state_nxt = S_INIT0;
        end
      end
      S_INIT0: begin
        pend_nxt   = 1'b0;
        mreq.we    = 1'b1;
        mreq.waddr = '0;
        mreq.wdata = {1'b1, 3'b000, heap_units_r, 16'h0000};
        state_nxt  = S_INIT1;
      end
      S_INIT1: begin
        mreq.we    = 1'b1;
        mreq.waddr = heap_units_r;
        mreq.wdata = {16'h0000, 1'b1, 3'b000, heap_units_r};
        state_nxt  = S_IDLE;
      end
      S_IDLE: begin
        if (pend_r) begin
          state_nxt = S_INIT0;
        end else if (in_valid) begin
          status_nxt = ST_OK;
          data_nxt   = '0;
          unique case (req_t'(in_req_type))
            REQ_ALLOC: begin
              units_nxt = alloc_units;
              if (alloc_units > free_units_r) begin
                status_nxt = ST_NO_SPACE;
                state_nxt  = S_FIN;
              end else begin
                start_nxt = {4'h0, hint_r};
                cur_nxt   = {4'h0, hint_r};
                found_nxt = 1'b0;
                state_nxt = S_A_RD;
              end
            end
            REQ_FREE: begin
              m_nxt   = {4'h0, in_ptr_unit} - 16'd1;
              cur_nxt = '0;
              if (in_ptr_unit == '0 || (in_ptr_unit - 12'd1) >= heap_end_r) begin
                status_nxt = ST_BAD_PTR;
                state_nxt  = S_FIN;
              end else begin
                state_nxt = S_F_RD;
              end
            end
            REQ_EXTEND: begin
              units_nxt = {1'b0, in_byte_count[16:MARKER_SHIFT]};
              if (in_byte_count[16:MARKER_SHIFT] == '0) begin
                state_nxt = S_FIN;
              end else begin
                mreq.raddr = {4'h0, heap_end_r};
                state_nxt  = S_E1;
              end
            end
            REQ_CHECK: begin
              cur_nxt   = '0;
              total_nxt = '0;
              state_nxt = S_CK_LOOP;
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end

      // Best-fit walk over the region chain.
      S_A_RD: begin
        if (cur_r < {4'h0, heap_end_r}) begin
          mreq.raddr = cur_r;
          state_nxt  = S_A_EV;
        end else begin
          state_nxt = S_A_END;
        end
      end
      S_A_EV: begin
        if (q_nsz == '0) begin
          state_nxt = S_A_END;
        end else begin
          if (q_nfr && q_nsz >= units_r && (!found_r || q_nsz < bsize_r)) begin
            found_nxt = 1'b1;
            best_nxt  = cur_r;
            bsize_nxt = q_nsz;
          end
          cur_nxt   = cur_r + q_nsz;
          state_nxt = S_A_RD;
        end
      end
      S_A_END: begin
        if (found_r) begin
          state_nxt = S_SP0;
        end else if (start_r == '0) begin
          status_nxt = ST_NO_SPACE;
          state_nxt  = S_FIN;
        end else begin
          hint_nxt  = '0;
          start_nxt = '0;
          cur_nxt   = '0;
          state_nxt = S_A_RD;
        end
      end

      // Split the chosen region.
      S_SP0: begin
        wh_nxt    = mk_wh(cut, 1'b0, 1'b0, units_r, S_SP1);
        state_nxt = S_WH_RD;
      end
      S_SP1: begin
        if (cut != tail) begin
          wh_nxt    = mk_wh(cut, 1'b1, 1'b1, bsize_r - units_r, S_SP2);
          state_nxt = S_WH_RD;
        end else begin
          state_nxt = S_SP3;
        end
      end
      S_SP2: begin
        wh_nxt    = mk_wh(tail, 1'b0, 1'b1, bsize_r - units_r, S_SP3);
        state_nxt = S_WH_RD;
      end
      S_SP3: begin
        wh_nxt    = mk_wh(best_r, 1'b1, 1'b0, units_r, S_SP_DONE);
        state_nxt = S_WH_RD;
      end
      S_SP_DONE: begin
        if ({4'h0, hint_r} == best_r) begin
          hint_nxt = (cut != tail) ? cut[ADDR_W-1:0] : '0;
        end
        free_units_nxt = free_units_r - units_r;
        data_nxt       = best_r[ADDR_W-1:0] + 12'd1;
        state_nxt      = S_FIN;
      end

      // Free: find the marker on the chain, then mark and merge.
      S_F_RD: begin
        if (cur_r < m_r) begin
          mreq.raddr = cur_r;
          state_nxt  = S_F_EV;
        end else begin
          state_nxt = S_F_CHK;
        end
      end
      S_F_EV: begin
        if (q_nsz == '0) begin
          state_nxt = S_F_CHK;
        end else begin
          cur_nxt   = cur_r + q_nsz;
          state_nxt = S_F_RD;
        end
      end
      S_F_CHK: begin
        if (cur_r != m_r) begin
          status_nxt = ST_BAD_PTR;
          state_nxt  = S_FIN;
        end else begin
          mreq.raddr = m_r;
          state_nxt  = S_F_CHK2;
        end
      end
      S_F_CHK2: begin
        if (q_nfr || q_nsz == '0) begin
          status_nxt = ST_BAD_PTR;
          state_nxt  = S_FIN;
        end else begin
          s_nxt     = q_nsz;
          wh_nxt    = mk_wh(m_r, 1'b1, 1'b1, q_nsz, S_F_W2);
          state_nxt = S_WH_RD;
        end
      end
      S_F_W2: begin
        wh_nxt    = mk_wh(m_r + s_r, 1'b0, 1'b1, s_r, S_F_C1);
        state_nxt = S_WH_RD;
      end
      S_F_C1: begin
        free_units_nxt = free_units_r + s_r;
        x_nxt          = m_r;
        co_ret_nxt     = S_F_PRV;
        state_nxt      = S_C_RD0;
      end
      S_F_PRV: begin
        mreq.raddr = m_r;
        state_nxt  = S_F_PRV2;
      end
      S_F_PRV2: begin
        if (q_pfr) begin
          m_nxt      = m_r - q_psz;
          x_nxt      = m_r - q_psz;
          co_ret_nxt = S_F_HINT;
          state_nxt  = S_C_RD0;
        end else begin
          state_nxt = S_F_HINT;
        end
      end
      S_F_HINT: begin
        if (m_r < {4'h0, hint_r}) begin
          hint_nxt = m_r[ADDR_W-1:0];
        end
        state_nxt = S_FIN;
      end

      // Merge the region at x with the one after it when both are free.
      S_C_RD0: begin
        mreq.raddr = x_r;
        state_nxt  = S_C_E0;
      end
      S_C_E0: begin
        xs_nxt     = q_nsz;
        xf_nxt     = q_nfr;
        mreq.raddr = x_r + q_nsz;
        state_nxt  = S_C_E1;
      end
      S_C_E1: begin
        if (xf_r && q_nfr) begin
          xs_nxt    = xs_r + q_nsz;
          wh_nxt    = mk_wh(x_r, 1'b1, 1'b1, xs_r + q_nsz, S_C_W2);
          state_nxt = S_WH_RD;
        end else begin
          state_nxt = co_ret_r;
        end
      end
      S_C_W2: begin
        wh_nxt    = mk_wh(x_r + xs_r, 1'b0, 1'b1, xs_r, co_ret_r);
        state_nxt = S_WH_RD;
      end

      // Extend: grow the last region, or add a new free one.
      S_E1: begin
        m_nxt     = q_pfr ? ({4'h0, heap_end_r} - q_psz) : {4'h0, heap_end_r};
        state_nxt = S_E_RD;
      end
      S_E_RD: begin
        mreq.raddr = m_r;
        state_nxt  = S_E2;
      end
      S_E2: begin
        if (ext_end >= 17'(STORE_DEPTH) || ext_size > {1'b0, SIZE_MASK}) begin
          status_nxt = ST_OVERFLOW;
          state_nxt  = S_FIN;
        end else begin
          s_nxt     = ext_size;
          cur_nxt   = ext_end[UA_W-1:0];
          wh_nxt    = mk_wh(m_r, 1'b1, 1'b1, ext_size, S_E_W2);
          state_nxt = S_WH_RD;
        end
      end
      S_E_W2: begin
        heap_end_nxt = cur_r[ADDR_W-1:0];
        wh_nxt       = mk_wh(cur_r, 1'b0, 1'b1, s_r, S_E_W3);
        state_nxt    = S_WH_RD;
      end
      S_E_W3: begin
        wh_nxt    = mk_wh(cur_r, 1'b1, 1'b0, '0, S_E_DONE);
        state_nxt = S_WH_RD;
      end
      S_E_DONE: begin
        free_units_nxt = free_units_r + units_r;
        state_nxt      = S_FIN;
      end

      // Check: verify every region, then the hint, then the free total.
      S_CK_LOOP: begin
        ro_m_nxt   = cur_r;
        ro_ret_nxt = S_CK_ACC;
        state_nxt  = S_RO0;
      end
      S_CK_ACC: begin
        if (w_r[31]) begin
          total_nxt = total_r + {1'b0, w_r[30:16]};
        end
        if (cur_r == {4'h0, heap_end_r}) begin
          ro_m_nxt   = {4'h0, hint_r};
          ro_ret_nxt = S_CK_FIN;
          state_nxt  = S_RO0;
        end else begin
          cur_nxt   = cur_r + {1'b0, w_r[30:16]};
          state_nxt = S_CK_LOOP;
        end
      end
      S_CK_FIN: begin
        status_nxt = (total_r == free_units_r) ? ST_OK : ST_CHECK_BAD;
        state_nxt  = S_FIN;
      end

      // Tag consistency of the marker at ro_m; a failure ends the check.
      S_RO0: begin
        if (ro_m_r > {4'h0, heap_end_r}) begin
          status_nxt = ST_CHECK_BAD;
          state_nxt  = S_FIN;
        end else begin
          mreq.raddr = ro_m_r;
          state_nxt  = S_RO1;
        end
      end
      S_RO1: begin
        w_nxt = q;
        if (q_nsz != '0) begin
          if (ro_m_r + q_nsz > {4'h0, heap_end_r}) begin
            status_nxt = ST_CHECK_BAD;
            state_nxt  = S_FIN;
          end else begin
            mreq.raddr = ro_m_r + q_nsz;
            state_nxt  = S_RO2;
          end
        end else if (ro_m_r != {4'h0, heap_end_r}) begin
          status_nxt = ST_CHECK_BAD;
          state_nxt  = S_FIN;
        end else begin
          state_nxt = S_RO3;
        end
      end
      S_RO2: begin
        if (q[14:0] != w_r[30:16] || q_pfr != w_r[31]) begin
          status_nxt = ST_CHECK_BAD;
          state_nxt  = S_FIN;
        end else begin
          state_nxt = S_RO3;
        end
      end
      S_RO3: begin
        if (w_r[14:0] != '0) begin
          if ({1'b0, w_r[14:0]} > ro_m_r) begin
            status_nxt = ST_CHECK_BAD;
            state_nxt  = S_FIN;
          end else begin
            mreq.raddr = ro_m_r - {1'b0, w_r[14:0]};
            state_nxt  = S_RO4;
          end
        end else if (ro_m_r != '0) begin
          status_nxt = ST_CHECK_BAD;
          state_nxt  = S_FIN;
        end else begin
          state_nxt = S_RO5;
        end
      end
      S_RO4: begin
        if (q[30:16] != w_r[14:0] || q_nfr != w_r[15]) begin
          status_nxt = ST_CHECK_BAD;
          state_nxt  = S_FIN;
        end else begin
          state_nxt = S_RO5;
        end
      end
      S_RO5: begin
        if (w_r[15] && w_r[31]) begin
          status_nxt = ST_CHECK_BAD;
          state_nxt  = S_FIN;
        end else begin
          state_nxt = ro_ret_r;
        end
      end

      // Half-word update: read the marker, then write it back merged.
      S_WH_RD: begin
        if (wh_r.addr[UA_W-1:ADDR_W] != '0) begin
          state_nxt = wh_r.ret;
        end else begin
          mreq.raddr = wh_r.addr;
          state_nxt  = S_WH_WR;
        end
      end
      S_WH_WR: begin
        mreq.we    = 1'b1;
        mreq.waddr = wh_r.addr[ADDR_W-1:0];
        mreq.wdata = wh_r.hi ? {wh_r.val, q[15:0]} : {q[31:16], wh_r.val};
        state_nxt  = wh_r.ret;
      end

      // Hand the result to the output register once it is free.
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_data_nxt   = data_r;
          out_free_nxt   = {free_units_r[11:0], 2'b00};
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // A heap size write reinitializes the heap registers and the markers.
    if (cfg_we) begin
      heap_units_nxt = clamp_units;
      heap_end_nxt   = clamp_units;
      free_units_nxt = {4'h0, clamp_units};
      hint_nxt       = '0;
      pend_nxt       = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      pend_r       <= 1'b1;
      clr_r        <= '0;
      heap_units_r <= MAX_UNITS;
      heap_end_r   <= MAX_UNITS;
      free_units_r <= {4'h0, MAX_UNITS};
      hint_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_r       <= pend_nxt;
      clr_r        <= clr_nxt;
      heap_units_r <= heap_units_nxt;
      heap_end_r   <= heap_end_nxt;
      free_units_r <= free_units_nxt;
      hint_r       <= hint_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    start_r      <= start_nxt;
    best_r       <= best_nxt;
    bsize_r      <= bsize_nxt;
    found_r      <= found_nxt;
    units_r      <= units_nxt;
    m_r          <= m_nxt;
    s_r          <= s_nxt;
    x_r          <= x_nxt;
    xs_r         <= xs_nxt;
    xf_r         <= xf_nxt;
    total_r      <= total_nxt;
    w_r          <= w_nxt;
    ro_m_r       <= ro_m_nxt;
    ro_ret_r     <= ro_ret_nxt;
    co_ret_r     <= co_ret_nxt;
    wh_r         <= wh_nxt;
    status_r     <= status_nxt;
    data_r       <= data_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_free_r   <= out_free_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_data_unit  = out_data_r;
  assign out_free_bytes = out_free_r;

  // An accepted word keeps the sequencer busy in the cycle after it is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted on two consecutive cycles");

  // Free space never exceeds the heap once the sequencer is idle.
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (free_units_r <= {4'h0, heap_end_r}))
    else $error("free unit count beyond heap end");

  // The marker store is never written while the sequencer waits for work.
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mreq.we)
    else $error("marker store written while idle");

  // Result status is always a defined code.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r <= ST_OVERFLOW))
    else $error("undefined result status");

endmodule
